FILE: design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, fixed-point constants and sector codes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Component precision; M = 2^COMPONENT_BITS - 1 stands for 1.0
    localparam int COMPONENT_BITS = 8;
    localparam int HUE_W          = 13;

    // One 60 degree sector in 1/16 degree units
    localparam int SECTOR_UNITS = 960;
    localparam int SECTOR_COUNT = 6;
    localparam int REM_W        = $clog2(SECTOR_UNITS);
    // Whole sectors that fit in the hue field (hue may wrap past 360 deg)
    localparam int NUM_BANDS    = (2 ** HUE_W - 1) / SECTOR_UNITS;
    localparam int CNT_W        = $clog2(NUM_BANDS + 1);

    // Common denominator 960*M for p, q and t
    localparam longint unsigned COMP_MAX = (64'd1 << COMPONENT_BITS) - 64'd1;
    localparam longint unsigned DEN      = SECTOR_UNITS * COMP_MAX;
    localparam int CW = $clog2(DEN + 1);          // coefficient width
    localparam int XW = COMPONENT_BITS + CW;      // numerator width
    localparam int RSW = REM_W + COMPONENT_BITS;  // rem*S width

    // Reciprocal of DEN scaled by 2^XW; estimate is exact or one low
    localparam longint unsigned RECIP = (64'd1 << XW) / DEN;
    localparam int RW = $clog2(RECIP + 1);

    // Stream word widths, padded to whole bytes
    localparam int S_DATA_W = ((HUE_W + 2 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * COMPONENT_BITS + 7) / 8) * 8;

    // Hue sectors
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    // Start of band n in hue units
    function automatic logic [HUE_W-1:0] band_base(input logic [CNT_W-1:0] n);
        return HUE_W'(int'(n) * SECTOR_UNITS);
    endfunction

    // Band number folded into the six sectors
    function automatic sector_t band_to_sector(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] f;
        f = (n >= CNT_W'(SECTOR_COUNT)) ? n - CNT_W'(SECTOR_COUNT) : n;
        return sector_t'(f[2:0]);
    endfunction

endpackage

FILE: design/hsv_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb
// Streaming HSV to RGB pixel converter, nine-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns it from the output register; the
// pipeline moves as a whole and holds when the result word is not taken, so
// the throughput is one word per cycle as long as m_tready stays high. Hue is
// in 1/16 degree (sector = 960 units), saturation and brightness are
// fractions of 255. p, q and t are formed over one common denominator
// 960*255 and each is divided by a reciprocal multiply with a one-step
// correction. Components are truncated toward zero.
module hsv_to_rgb
    import hsv2rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // hue[12:0], saturation, brightness
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // red, green, blue
);

    localparam int CB = COMPONENT_BITS;

    // Pipeline advances whenever the output slot is free or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [8:0] vld_reg;

    // Input field unpack
    logic [HUE_W-1:0] in_hue;
    logic [CB-1:0]    in_sat, in_val;
    assign in_hue = s_tdata[HUE_W-1:0];
    assign in_sat = s_tdata[HUE_W +: CB];
    assign in_val = s_tdata[HUE_W+CB +: CB];

    // Stage 1: band count by independent threshold compares
    logic [CNT_W-1:0] cnt_next, cnt_reg;
    logic [HUE_W-1:0] hue1_reg;
    logic [CB-1:0]    sat1_reg, val1_reg;

    always_comb begin
        cnt_next = '0;
        for (int k = 1; k <= NUM_BANDS; k++) begin
            if (in_hue >= HUE_W'(k * SECTOR_UNITS)) begin
                cnt_next = cnt_next + CNT_W'(1);
            end
        end
    end

    // Stage 2: sector and position in sector
    logic [HUE_W-1:0] rem_full;
    logic [REM_W-1:0] rem2_reg;
    sector_t          sec2_reg;
    logic [CB-1:0]    sat2_reg, val2_reg;
    assign rem_full = hue1_reg - band_base(cnt_reg);

    // Stage 3: rem*S and 960*S
    logic [RSW-1:0] rs3_reg;
    logic [CW-1:0]  s960_3_reg;
    sector_t        sec3_reg;
    logic [CB-1:0]  val3_reg;

    // Stage 4: coefficients of V for p, q, t
    logic [CW-1:0] cp4_reg, cq4_reg, ct4_reg;
    sector_t       sec4_reg;
    logic [CB-1:0] val4_reg;

    // Stage 5: numerators
    logic [XW-1:0] xp5_reg, xq5_reg, xt5_reg;
    sector_t       sec5_reg;
    logic [CB-1:0] val5_reg;

    // Stage 6: quotient estimates
    logic [XW+RW-1:0] ep_full, eq_full, et_full;
    logic [CB-1:0]    ep6_reg, eq6_reg, et6_reg;
    logic [XW-1:0]    xp6_reg, xq6_reg, xt6_reg;
    sector_t          sec6_reg;
    logic [CB-1:0]    val6_reg;
    assign ep_full = (XW+RW)'(xp5_reg) * (XW+RW)'(RECIP);
    assign eq_full = (XW+RW)'(xq5_reg) * (XW+RW)'(RECIP);
    assign et_full = (XW+RW)'(xt5_reg) * (XW+RW)'(RECIP);

    // Stage 7: residuals numerator - estimate*DEN
    logic [XW-1:0] resp7_reg, resq7_reg, rest7_reg;
    logic [CB-1:0] ep7_reg, eq7_reg, et7_reg;
    sector_t       sec7_reg;
    logic [CB-1:0] val7_reg;

    // Stage 8: corrected p, q, t
    logic [CB-1:0] p8_reg, q8_reg, t8_reg;
    sector_t       sec8_reg;
    logic [CB-1:0] val8_reg;

    // Output select per sector
    logic [CB-1:0] r_next, g_next, b_next;
    logic [CB-1:0] r_reg, g_reg, b_reg;

    always_comb begin
        case (sec8_reg)
            SEC_R_TO_Y: begin r_next = val8_reg; g_next = t8_reg;   b_next = p8_reg;   end
            SEC_Y_TO_G: begin r_next = q8_reg;   g_next = val8_reg; b_next = p8_reg;   end
            SEC_G_TO_C: begin r_next = p8_reg;   g_next = val8_reg; b_next = t8_reg;   end
            SEC_C_TO_B: begin r_next = p8_reg;   g_next = q8_reg;   b_next = val8_reg; end
            SEC_B_TO_M: begin r_next = t8_reg;   g_next = p8_reg;   b_next = val8_reg; end
            default:    begin r_next = val8_reg; g_next = p8_reg;   b_next = q8_reg;   end
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[7:0], s_tvalid};
        end
    end

    // Data path registers
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            cnt_reg  <= cnt_next;
            hue1_reg <= in_hue;
            sat1_reg <= in_sat;
            val1_reg <= in_val;
            // stage 2
            rem2_reg <= rem_full[REM_W-1:0];
            sec2_reg <= band_to_sector(cnt_reg);
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
            // stage 3
            rs3_reg    <= RSW'(rem2_reg) * RSW'(sat2_reg);
            s960_3_reg <= CW'(sat2_reg) * CW'(SECTOR_UNITS);
            sec3_reg   <= sec2_reg;
            val3_reg   <= val2_reg;
            // stage 4
            cp4_reg  <= CW'(DEN) - s960_3_reg;
            cq4_reg  <= CW'(DEN) - CW'(rs3_reg);
            ct4_reg  <= CW'(DEN) - s960_3_reg + CW'(rs3_reg);
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
            // stage 5
            xp5_reg  <= XW'(val4_reg) * XW'(cp4_reg);
            xq5_reg  <= XW'(val4_reg) * XW'(cq4_reg);
            xt5_reg  <= XW'(val4_reg) * XW'(ct4_reg);
            sec5_reg <= sec4_reg;
            val5_reg <= val4_reg;
            // stage 6
            ep6_reg  <= ep_full[XW +: CB];
            eq6_reg  <= eq_full[XW +: CB];
            et6_reg  <= et_full[XW +: CB];
            xp6_reg  <= xp5_reg;
            xq6_reg  <= xq5_reg;
            xt6_reg  <= xt5_reg;
            sec6_reg <= sec5_reg;
            val6_reg <= val5_reg;
            // stage 7
            resp7_reg <= xp6_reg - XW'(ep6_reg) * XW'(DEN);
            resq7_reg <= xq6_reg - XW'(eq6_reg) * XW'(DEN);
            rest7_reg <= xt6_reg - XW'(et6_reg) * XW'(DEN);
            ep7_reg   <= ep6_reg;
            eq7_reg   <= eq6_reg;
            et7_reg   <= et6_reg;
            sec7_reg  <= sec6_reg;
            val7_reg  <= val6_reg;
            // stage 8: estimate is one low when the residual reaches DEN
            p8_reg   <= ep7_reg + CB'(resp7_reg >= XW'(DEN));
            q8_reg   <= eq7_reg + CB'(resq7_reg >= XW'(DEN));
            t8_reg   <= et7_reg + CB'(rest7_reg >= XW'(DEN));
            sec8_reg <= sec7_reg;
            val8_reg <= val7_reg;
            // output word
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign m_tvalid = vld_reg[8];
    assign m_tdata  = M_DATA_W'({b_reg, g_reg, r_reg});

endmodule
